>>> hdl/gzhp_pkg.sv
package gzhp_pkg;

  localparam logic [15:0] GZ_MAGIC          = 16'h8b1f;
  localparam logic [7:0]  GZ_METHOD_DEFLATE = 8'd8;
  localparam int          GZ_FIXED_LEN      = 10;
  localparam int          GZ_FOOTER_LEN     = 8;
  localparam int          GZ_FLG_HCRC       = 1;
  localparam int          GZ_FLG_EXTRA      = 2;
  localparam int          GZ_FLG_NAME       = 3;
  localparam int          GZ_FLG_COMMENT    = 4;
  localparam logic [31:0] GZ_SIZE_LIMIT_RESET = 32'd536870912;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_INPUT  = 3'd1;
  localparam logic [2:0] ST_TOO_SHORT = 3'd2;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd3;
  localparam logic [2:0] ST_BAD_METHOD = 3'd4;
  localparam logic [2:0] ST_TOO_LARGE = 3'd5;

  localparam logic [1:0] CLS_HEADER  = 2'd0;
  localparam logic [1:0] CLS_PAYLOAD = 2'd1;
  localparam logic [1:0] CLS_FOOTER  = 2'd2;

  localparam logic REG_STREAM_LENGTH = 1'b0;
  localparam logic REG_SIZE_LIMIT    = 1'b1;

  typedef struct packed {
    logic [1:0]  byte_class;
    logic [7:0]  out_byte;
    logic        is_last;
    logic [2:0]  status;
    logic [31:0] payload_start;
    logic [31:0] expected_crc;
    logic [31:0] expected_size;
  } result_t;

endpackage

>>> hdl/gzip_member_header_footer_parser.sv
// Parses one gzip member per stream_length bytes, one byte per beat, and returns one result
// beat per input beat: the byte itself, its class (header, deflate payload or footer) and, on
// the final byte, the payload start offset, the stored CRC32 and size and a status code. The
// block takes one byte every cycle unless a result waits in the skid entry; the header walk
// state and the byte offset adder are updated in the same cycle the byte is accepted, and a
// two-entry output buffer lets a byte be accepted while an earlier result still waits on
// out_ready. Write stream_length and size_limit only between members.
module gzip_member_header_footer_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_byte_class,
  output logic [7:0]  out_out_byte,
  output logic        out_is_last,
  output logic [2:0]  out_status,
  output logic [31:0] out_payload_start,
  output logic [31:0] out_expected_crc,
  output logic [31:0] out_expected_size
);

  typedef enum logic [2:0] {
    PH_FIXED   = 3'd0,
    PH_XLEN    = 3'd1,
    PH_EXTRA   = 3'd2,
    PH_NAME    = 3'd3,
    PH_COMMENT = 3'd4,
    PH_HCRC    = 3'd5,
    PH_PAYLOAD = 3'd6
  } phase_t;

  function automatic phase_t enter_after(input phase_t stage, input logic [7:0] flags);
    phase_t ph;
    if (stage < PH_NAME && flags[gzhp_pkg::GZ_FLG_NAME]) begin
      ph = PH_NAME;
    end else if (stage < PH_COMMENT && flags[gzhp_pkg::GZ_FLG_COMMENT]) begin
      ph = PH_COMMENT;
    end else if (stage < PH_HCRC && flags[gzhp_pkg::GZ_FLG_HCRC]) begin
      ph = PH_HCRC;
    end else begin
      ph = PH_PAYLOAD;
    end
    return ph;
  endfunction

  logic [31:0] len_r, limit_r;

  logic [31:0] pos_r, pos_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [15:0] magic_r, magic_nxt;
  logic [15:0] xlen_r, xlen_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [32:0] off_r, off_nxt;
  logic [63:0] fs_r, fs_nxt;
  logic [2:0]  err_r, err_nxt;

  gzhp_pkg::result_t out_r, skid_r, res;
  logic out_valid_r, skid_valid_r;

  logic        push, pop, last, in_footer, ent;
  phase_t      ent_from, ent_ph;
  logic [15:0] skip_dec;
  logic [33:0] off_f;
  logic [7:0]  b;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == gzhp_pkg::REG_SIZE_LIMIT) ? limit_r : len_r;
  assign in_ready = !skid_valid_r;
  assign push     = in_valid && in_ready;
  assign pop      = out_valid_r && out_ready;
  assign b        = in_data_byte;

  assign last      = ({1'b0, pos_r} + 33'd1) >= {1'b0, len_r};
  assign in_footer = (len_r >= 32'(gzhp_pkg::GZ_FOOTER_LEN)) &&
                     (({1'b0, pos_r} + 33'(gzhp_pkg::GZ_FOOTER_LEN)) >= {1'b0, len_r});
  assign skip_dec  = (skip_r != 16'd0) ? skip_r - 16'd1 : skip_r;

  always_comb begin
    pos_nxt   = pos_r + 32'd1;
    phase_nxt = phase_r;
    flags_nxt = flags_r;
    magic_nxt = magic_r;
    xlen_nxt  = xlen_r;
    skip_nxt  = skip_r;
    off_nxt   = off_r;
    fs_nxt    = {b, fs_r[63:8]};
    err_nxt   = err_r;
    ent       = 1'b0;
    ent_from  = PH_EXTRA;
    ent_ph    = PH_PAYLOAD;

    if (pos_r == 32'd10) begin
      xlen_nxt = {8'd0, b};
    end else if (pos_r == 32'd11) begin
      xlen_nxt = xlen_r | {b, 8'd0};
    end

    case (phase_r)
      PH_FIXED: begin
        if (pos_r == 32'd0) begin
          magic_nxt = {8'd0, b};
        end else if (pos_r == 32'd1) begin
          magic_nxt = magic_r | {b, 8'd0};
        end else if (pos_r == 32'd2) begin
          if (magic_r != gzhp_pkg::GZ_MAGIC) begin
            err_nxt = gzhp_pkg::ST_BAD_MAGIC;
          end else if (b != gzhp_pkg::GZ_METHOD_DEFLATE) begin
            err_nxt = gzhp_pkg::ST_BAD_METHOD;
          end
        end else if (pos_r == 32'd3) begin
          flags_nxt = b;
        end else if (pos_r >= 32'(gzhp_pkg::GZ_FIXED_LEN - 1)) begin
          off_nxt = 33'(gzhp_pkg::GZ_FIXED_LEN);
          if (flags_r[gzhp_pkg::GZ_FLG_EXTRA]) begin
            phase_nxt = PH_XLEN;
          end else begin
            ent = 1'b1;
          end
        end
      end
      PH_XLEN: begin
        if (pos_r >= 32'd11) begin
          off_nxt = off_r + 33'd2 + {17'd0, xlen_nxt};
          if (xlen_nxt == 16'd0) begin
            ent = 1'b1;
          end else begin
            skip_nxt  = xlen_nxt;
            phase_nxt = PH_EXTRA;
          end
        end
      end
      PH_EXTRA: begin
        skip_nxt = skip_dec;
        if (skip_dec == 16'd0) begin
          ent = 1'b1;
        end
      end
      PH_NAME, PH_COMMENT: begin
        off_nxt = off_r + 33'd1;
        if (b == 8'd0) begin
          ent      = 1'b1;
          ent_from = phase_r;
        end
      end
      PH_HCRC: begin
        skip_nxt = skip_dec;
        if (skip_dec == 16'd0) begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      default: begin
      end
    endcase

    if (ent) begin
      ent_ph    = enter_after(ent_from, flags_nxt);
      phase_nxt = ent_ph;
      if (ent_ph == PH_HCRC) begin
        skip_nxt = 16'd2;
        off_nxt  = off_nxt + 33'd2;
      end
    end

    off_f = {1'b0, off_nxt};
    if (phase_nxt < PH_HCRC && flags_nxt[gzhp_pkg::GZ_FLG_HCRC]) begin
      off_f = off_f + 34'd2;
    end

    res.byte_class    = in_footer ? gzhp_pkg::CLS_FOOTER :
                        ((phase_r != PH_PAYLOAD) ? gzhp_pkg::CLS_HEADER :
                         gzhp_pkg::CLS_PAYLOAD);
    res.out_byte      = b;
    res.is_last       = last;
    res.status        = gzhp_pkg::ST_OK;
    res.payload_start = 32'd0;
    res.expected_crc  = 32'd0;
    res.expected_size = 32'd0;

    if (last) begin
      if (len_r <= 32'(gzhp_pkg::GZ_FIXED_LEN + gzhp_pkg::GZ_FOOTER_LEN)) begin
        res.status = gzhp_pkg::ST_NO_INPUT;
      end else begin
        res.expected_crc  = fs_nxt[31:0];
        res.expected_size = fs_nxt[63:32];
        res.payload_start = off_f[31:0];
        if ((off_f + 34'(gzhp_pkg::GZ_FOOTER_LEN)) >= {2'd0, len_r}) begin
          res.status = gzhp_pkg::ST_TOO_SHORT;
        end else if (err_nxt != gzhp_pkg::ST_OK) begin
          res.status = err_nxt;
        end else if (fs_nxt[63:32] >= limit_r) begin
          res.status = gzhp_pkg::ST_TOO_LARGE;
        end
      end
      pos_nxt   = 32'd0;
      phase_nxt = PH_FIXED;
      flags_nxt = 8'd0;
      magic_nxt = 16'd0;
      xlen_nxt  = 16'd0;
      skip_nxt  = 16'd0;
      off_nxt   = 33'(gzhp_pkg::GZ_FIXED_LEN);
      fs_nxt    = 64'd0;
      err_nxt   = gzhp_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r        <= 32'd0;
      limit_r      <= gzhp_pkg::GZ_SIZE_LIMIT_RESET;
      pos_r        <= 32'd0;
      phase_r      <= PH_FIXED;
      flags_r      <= 8'd0;
      magic_r      <= 16'd0;
      xlen_r       <= 16'd0;
      skip_r       <= 16'd0;
      off_r        <= 33'(gzhp_pkg::GZ_FIXED_LEN);
      fs_r         <= 64'd0;
      err_r        <= gzhp_pkg::ST_OK;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == gzhp_pkg::REG_STREAM_LENGTH) begin
          len_r <= pwdata;
        end else begin
          limit_r <= pwdata;
        end
      end
      if (push) begin
        pos_r   <= pos_nxt;
        phase_r <= phase_nxt;
        flags_r <= flags_nxt;
        magic_r <= magic_nxt;
        xlen_r  <= xlen_nxt;
        skip_r  <= skip_nxt;
        off_r   <= off_nxt;
        fs_r    <= fs_nxt;
        err_r   <= err_nxt;
      end
      if (!out_valid_r || out_ready) begin
        if (skid_valid_r) begin
          out_r        <= skid_r;
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_r       <= res;
          out_valid_r <= push;
        end
      end else if (push) begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte_class    = out_r.byte_class;
  assign out_out_byte      = out_r.out_byte;
  assign out_is_last       = out_r.is_last;
  assign out_status        = out_r.status;
  assign out_payload_start = out_r.payload_start;
  assign out_expected_crc  = out_r.expected_crc;
  assign out_expected_size = out_r.expected_size;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register is empty");

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push && last) |=> (pos_r == 32'd0 && phase_r == PH_FIXED && err_r == gzhp_pkg::ST_OK))
    else $error("parser did not restart after the final byte");

  a_status_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.is_last) |-> (out_r.status == gzhp_pkg::ST_OK &&
                                         out_r.payload_start == 32'd0))
    else $error("summary fields set on a byte that is not final");

  a_no_loss_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("stalled result beat dropped");

endmodule
